@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CTS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("cts assertion failed");

// condition in one cycle implies property in the next
`define CTS_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("cts assertion failed");

`endif

@@ hdl/cts_pkg.sv @@
`timescale 1ns / 1ps

package cts_pkg;

    localparam int MAX_TERMS_DEF = 32;

    localparam int X_W       = 32;
    localparam int SUM_W     = 48;
    localparam int TERMS_W   = 6;
    localparam int TERMS_MAX = (1 << TERMS_W) - 1;
    localparam int CNT_CFG_W = 6;
    localparam int THR_W     = 31;
    localparam int CFG_IDX_W = 2;

    localparam int MAG_W   = 62;
    localparam int Y_W     = 37;
    localparam int RECIP_W = 40;
    localparam int LIMB_W  = 32;
    localparam int PP_W    = LIMB_W + RECIP_W;
    localparam int PROD_W  = 104;
    localparam int ACC_W   = 64;
    localparam int SQ_SH   = 26;
    localparam int FRAC_W  = 28;
    localparam int STEP_W  = 4;

    localparam logic [STEP_W-1:0] STEP_TERM_TOP = 4'd3;
    localparam logic [STEP_W-1:0] STEP_LAST     = 4'd11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP_MODE  = 2'd0,
        CFG_TERM_COUNT = 2'd1,
        CFG_THRESHOLD  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        SRC_XX,
        SRC_MY,
        SRC_PR
    } t_src;

    typedef enum logic [1:0] {
        POP_NONE,
        POP_CLEAR,
        POP_ADD
    } t_pop;

    typedef enum logic [1:0] {
        RND_NONE,
        RND_Y,
        RND_P1,
        RND_M
    } t_rnd;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_LOOP,
        JMP_DONE
    } t_jmp;

    typedef struct packed {
        t_src              src;
        logic              mul_en;
        logic              a_hi;
        t_pop              pop;
        t_rnd              rnd;
        logic              term;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_uword;

    localparam t_uword UW_NOP = '{
        src: SRC_XX, mul_en: 1'b0, a_hi: 1'b0, pop: POP_NONE,
        rnd: RND_NONE, term: 1'b0, jmp: JMP_NEXT, target: '0
    };

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = UW_NOP;
        case (step)
            // y = round(|x|^2 / 2^26)
            4'd0: begin
                w.src = SRC_XX; w.mul_en = 1'b1; w.pop = POP_CLEAR;
            end
            4'd1: begin
                w.pop = POP_ADD;
            end
            4'd2: begin
                w.rnd = RND_Y; w.jmp = JMP_LOOP; w.target = STEP_TERM_TOP;
            end
            // p = round(m * y / 2^28)
            4'd3: begin
                w.src = SRC_MY; w.mul_en = 1'b1; w.pop = POP_CLEAR;
            end
            4'd4: begin
                w.src = SRC_MY; w.mul_en = 1'b1; w.a_hi = 1'b1; w.pop = POP_ADD;
            end
            4'd5: begin
                w.pop = POP_ADD;
            end
            4'd6: begin
                w.rnd = RND_P1;
            end
            // m = round(p * r / 2^40)
            4'd7: begin
                w.src = SRC_PR; w.mul_en = 1'b1; w.pop = POP_CLEAR;
            end
            4'd8: begin
                w.src = SRC_PR; w.mul_en = 1'b1; w.a_hi = 1'b1; w.pop = POP_ADD;
            end
            4'd9: begin
                w.pop = POP_ADD;
            end
            4'd10: begin
                w.rnd = RND_M;
            end
            // accumulate and test
            4'd11: begin
                w.term = 1'b1; w.jmp = JMP_LOOP; w.target = STEP_TERM_TOP;
            end
            default: begin
                w.jmp = JMP_DONE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ hdl/cts_in_if.sv @@
`timescale 1ns / 1ps

interface cts_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [cts_pkg::X_W-1:0]    x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

@@ hdl/cts_out_if.sv @@
`timescale 1ns / 1ps

interface cts_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [cts_pkg::SUM_W-1:0]    series_sum;
    logic        [cts_pkg::TERMS_W-1:0]  terms_used;
    logic                                limit_hit;

    modport source (output valid, output series_sum, output terms_used, output limit_hit,
                    input ready);
    modport sink   (input valid, input series_sum, input terms_used, input limit_hit,
                    output ready);
endinterface

@@ hdl/cosine_taylor_series_sum_top.sv @@
// Partial Taylor sum of cos(2x) - 1 for a signed Q3.28 argument.
// Input channel i_x carries one word, x_value; output channel o_res carries
// series_sum (Q19.28, saturated), terms_used and limit_hit. Both use valid/ready.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 stop_mode, 1 term_count, 2 accuracy_threshold); write only while idle.
// A microcoded sequencer drives one 32 x 40 bit multiplier: the square of x
// takes 3 steps, then each term takes 9 steps (two multiplies of two partial
// products each, two rounding steps, one accumulate and test).
// The sequencer returns to idle in the same cycle that the result turns valid,
// so the next word can be accepted while the result is still on offer.
// Only one word is in work at a time; ready is high while the sequencer idles.
// The result sits in an output register: a new word is accepted while it
// waits, and if the receiver still stalls when the next result is finished,
// the sequencer holds that result until the output register frees up.
// Reset sets stop_mode 0, term_count 8, accuracy_threshold 268, and empties
// both channels.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cosine_taylor_series_sum_top #(
    parameter int MAX_TERMS = cts_pkg::MAX_TERMS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cts_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cts_pkg::THR_W-1:0]       i_cfg_data,
    cts_in_if.sink                          i_x,
    cts_out_if.source                       o_res
);

    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int MAG_W  = cts_pkg::MAG_W;
    localparam int PROD_W = cts_pkg::PROD_W;
    localparam int ACC_W  = cts_pkg::ACC_W;
    localparam int LIMB_W = cts_pkg::LIMB_W;
    localparam int RCP_W  = cts_pkg::RECIP_W;
    localparam int SUM_W  = cts_pkg::SUM_W;

    localparam logic signed [ACC_W:0] ACC_CAP = signed'((ACC_W + 1)'(1) << MAG_W);
    localparam logic [MAG_W-1:0]      MAG_ONE = MAG_W'(1) << cts_pkg::FRAC_W;

    // reciprocal table, round(2^40 / ((2n-1)(2n)))
    logic [RCP_W-1:0] w_recip [MAX_TERMS];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TERMS; gi++) begin : g_recip
            localparam longint unsigned REC_DEN =
                longint'(2 * gi + 1) * longint'(2 * gi + 2);
            localparam longint unsigned REC_VAL =
                ((64'd1 << RCP_W) + REC_DEN / 2) / REC_DEN;
            assign w_recip[gi] = RCP_W'(REC_VAL);
        end
    endgenerate

    cts_pkg::t_state              r_state, n_state;
    logic [cts_pkg::STEP_W-1:0]   r_step, n_step;
    logic                         r_stop_mode, n_stop_mode;
    logic [cts_pkg::CNT_CFG_W-1:0] r_term_count, n_term_count;
    logic [cts_pkg::THR_W-1:0]    r_threshold, n_threshold;
    logic                         r_ovalid, n_ovalid;
    logic [CNT_W-1:0]             r_n, n_n;

    logic [cts_pkg::X_W-1:0]      r_ax, n_ax;
    logic [cts_pkg::Y_W-1:0]      r_y, n_y;
    logic [MAG_W-1:0]             r_m, n_m;
    logic [MAG_W-1:0]             r_p1, n_p1;
    logic [cts_pkg::PP_W-1:0]     r_pp, n_pp;
    logic                         r_pp_hi, n_pp_hi;
    logic [PROD_W-1:0]            r_prod, n_prod;
    logic signed [ACC_W-1:0]      r_acc, n_acc;
    logic                         r_lim, n_lim;
    logic signed [SUM_W-1:0]      r_osum, n_osum;
    logic [cts_pkg::TERMS_W-1:0]  r_oterms, n_oterms;
    logic                         r_oflag, n_oflag;

    cts_pkg::t_uword              w_uw;
    logic [CNT_W-1:0]             w_limit;
    logic                         w_more;
    logic                         w_stop;
    logic [MAG_W-1:0]             w_opa;
    logic [RCP_W-1:0]             w_opb;
    logic [LIMB_W-1:0]            w_limb;
    logic [cts_pkg::PP_W-1:0]     w_pp;
    logic [PROD_W-1:0]            w_prod_add;
    logic [PROD_W-1:0]            w_rnd_sum;
    logic [PROD_W-1:0]            w_rnd_val;
    logic [MAG_W-1:0]             w_rnd_sat;
    logic signed [ACC_W:0]        w_acc_sum;
    logic signed [ACC_W:0]        w_acc_clip;
    logic                         w_pos_sat;
    logic                         w_neg_sat;
    logic                         w_out_free;

    assign w_uw = cts_pkg::ucode(r_step);

    assign w_limit = r_stop_mode ? CNT_W'(MAX_TERMS) :
                     ((32'(r_term_count) < MAX_TERMS) ? CNT_W'(r_term_count)
                                                      : CNT_W'(MAX_TERMS));
    assign w_more = (r_n < w_limit);
    assign w_stop = r_stop_mode && (r_m < MAG_W'(r_threshold));

    // shared multiplier operands
    always_comb begin
        case (w_uw.src)
            cts_pkg::SRC_XX: begin
                w_opa = MAG_W'(r_ax);
                w_opb = RCP_W'(r_ax);
            end
            cts_pkg::SRC_MY: begin
                w_opa = r_m;
                w_opb = RCP_W'(r_y);
            end
            cts_pkg::SRC_PR: begin
                w_opa = r_p1;
                w_opb = w_recip[r_n[IDX_W-1:0]];
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    assign w_limb = w_uw.a_hi ? LIMB_W'(w_opa[MAG_W-1:LIMB_W]) : w_opa[LIMB_W-1:0];
    assign w_pp   = cts_pkg::PP_W'(w_limb) * cts_pkg::PP_W'(w_opb);

    assign w_prod_add = r_prod + (r_pp_hi ? (PROD_W'(r_pp) << LIMB_W) : PROD_W'(r_pp));

    // round half up, then shift
    always_comb begin
        case (w_uw.rnd)
            cts_pkg::RND_Y: begin
                w_rnd_sum = r_prod + (PROD_W'(1) << (cts_pkg::SQ_SH - 1));
                w_rnd_val = w_rnd_sum >> cts_pkg::SQ_SH;
            end
            cts_pkg::RND_P1: begin
                w_rnd_sum = r_prod + (PROD_W'(1) << (cts_pkg::FRAC_W - 1));
                w_rnd_val = w_rnd_sum >> cts_pkg::FRAC_W;
            end
            cts_pkg::RND_M: begin
                w_rnd_sum = r_prod + (PROD_W'(1) << (RCP_W - 1));
                w_rnd_val = w_rnd_sum >> RCP_W;
            end
            default: begin
                w_rnd_sum = '0;
                w_rnd_val = '0;
            end
        endcase
    end

    assign w_rnd_sat = (|w_rnd_val[PROD_W-1:MAG_W]) ? {MAG_W{1'b1}} : w_rnd_val[MAG_W-1:0];

    // odd terms are negative
    always_comb begin
        if (r_n[0]) begin
            w_acc_sum = {r_acc[ACC_W-1], r_acc} - signed'({{(ACC_W + 1 - MAG_W){1'b0}}, r_m});
        end else begin
            w_acc_sum = {r_acc[ACC_W-1], r_acc} + signed'({{(ACC_W + 1 - MAG_W){1'b0}}, r_m});
        end
        if (w_acc_sum > ACC_CAP) begin
            w_acc_clip = ACC_CAP;
        end else if (w_acc_sum < -ACC_CAP) begin
            w_acc_clip = -ACC_CAP;
        end else begin
            w_acc_clip = w_acc_sum;
        end
    end

    assign w_pos_sat = !r_acc[ACC_W-1] && (|r_acc[ACC_W-2:SUM_W-1]);
    assign w_neg_sat = r_acc[ACC_W-1] && !(&r_acc[ACC_W-2:SUM_W-1]);

    assign w_out_free = !r_ovalid || o_res.ready;

    assign i_x.ready        = (r_state == cts_pkg::ST_IDLE);
    assign o_res.valid      = r_ovalid;
    assign o_res.series_sum = r_osum;
    assign o_res.terms_used = r_oterms;
    assign o_res.limit_hit  = r_oflag;

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_stop_mode  = r_stop_mode;
        n_term_count = r_term_count;
        n_threshold  = r_threshold;
        n_ovalid     = r_ovalid && !o_res.ready;
        n_n          = r_n;
        n_ax         = r_ax;
        n_y          = r_y;
        n_m          = r_m;
        n_p1         = r_p1;
        n_pp         = r_pp;
        n_pp_hi      = r_pp_hi;
        n_prod       = r_prod;
        n_acc        = r_acc;
        n_lim        = r_lim;
        n_osum       = r_osum;
        n_oterms     = r_oterms;
        n_oflag      = r_oflag;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                cts_pkg::CFG_STOP_MODE:  n_stop_mode  = i_cfg_data[0];
                cts_pkg::CFG_TERM_COUNT: n_term_count = i_cfg_data[cts_pkg::CNT_CFG_W-1:0];
                cts_pkg::CFG_THRESHOLD:  n_threshold  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            cts_pkg::ST_IDLE: begin
                if (i_x.valid) begin
                    n_ax    = i_x.x_value[cts_pkg::X_W-1] ?
                              cts_pkg::X_W'(~i_x.x_value + 1'b1) : i_x.x_value;
                    n_m     = MAG_ONE;
                    n_acc   = '0;
                    n_n     = '0;
                    n_lim   = 1'b0;
                    n_step  = '0;
                    n_state = cts_pkg::ST_RUN;
                end
            end
            cts_pkg::ST_RUN: begin
                if (w_uw.mul_en) begin
                    n_pp    = w_pp;
                    n_pp_hi = w_uw.a_hi;
                end
                case (w_uw.pop)
                    cts_pkg::POP_CLEAR: n_prod = '0;
                    cts_pkg::POP_ADD:   n_prod = w_prod_add;
                    default: ;
                endcase
                case (w_uw.rnd)
                    cts_pkg::RND_Y:  n_y  = w_rnd_sat[cts_pkg::Y_W-1:0];
                    cts_pkg::RND_P1: n_p1 = w_rnd_sat;
                    cts_pkg::RND_M: begin
                        n_m = w_rnd_sat;
                        n_n = r_n + 1'b1;
                    end
                    default: ;
                endcase
                if (w_uw.term) begin
                    n_acc = ACC_W'(w_acc_clip);
                end
                case (w_uw.jmp)
                    cts_pkg::JMP_NEXT: begin
                        n_step = r_step + 1'b1;
                    end
                    cts_pkg::JMP_LOOP: begin
                        if (w_uw.term && w_stop) begin
                            n_lim   = 1'b0;
                            n_state = cts_pkg::ST_DONE;
                        end else if (w_more) begin
                            n_step = w_uw.target;
                        end else begin
                            n_lim   = r_stop_mode;
                            n_state = cts_pkg::ST_DONE;
                        end
                    end
                    default: begin
                        n_lim   = r_stop_mode;
                        n_state = cts_pkg::ST_DONE;
                    end
                endcase
            end
            cts_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    if (w_pos_sat) begin
                        n_osum = {1'b0, {(SUM_W - 1){1'b1}}};
                    end else if (w_neg_sat) begin
                        n_osum = {1'b1, {(SUM_W - 1){1'b0}}};
                    end else begin
                        n_osum = r_acc[SUM_W-1:0];
                    end
                    n_oterms = (32'(r_n) > cts_pkg::TERMS_MAX) ?
                               cts_pkg::TERMS_W'(cts_pkg::TERMS_MAX) : cts_pkg::TERMS_W'(r_n);
                    n_oflag  = r_lim || w_pos_sat || w_neg_sat;
                    n_state  = cts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cts_pkg::ST_IDLE;
            r_step       <= '0;
            r_stop_mode  <= 1'b0;
            r_term_count <= cts_pkg::CNT_CFG_W'(8);
            r_threshold  <= cts_pkg::THR_W'(268);
            r_ovalid     <= 1'b0;
            r_n          <= '0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_stop_mode  <= n_stop_mode;
            r_term_count <= n_term_count;
            r_threshold  <= n_threshold;
            r_ovalid     <= n_ovalid;
            r_n          <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax     <= n_ax;
        r_y      <= n_y;
        r_m      <= n_m;
        r_p1     <= n_p1;
        r_pp     <= n_pp;
        r_pp_hi  <= n_pp_hi;
        r_prod   <= n_prod;
        r_acc    <= n_acc;
        r_lim    <= n_lim;
        r_osum   <= n_osum;
        r_oterms <= n_oterms;
        r_oflag  <= n_oflag;
    end

    `CTS_ASSERT(a_step_range, i_clk, i_rst_n,
                (r_state != cts_pkg::ST_RUN) || (r_step <= cts_pkg::STEP_LAST))
    `CTS_ASSERT(a_count_bound, i_clk, i_rst_n, 32'(r_n) <= 32'(MAX_TERMS))
    `CTS_ASSERT_NEXT(a_start, i_clk, i_rst_n, i_x.valid && i_x.ready,
                     (r_state == cts_pkg::ST_RUN) && (r_step == '0))
    `CTS_ASSERT_NEXT(a_done_hold, i_clk, i_rst_n,
                     (r_state == cts_pkg::ST_DONE) && r_ovalid && !o_res.ready,
                     r_state == cts_pkg::ST_DONE)

endmodule
